### rtl/swd_pkg.sv
// shared types and codes for the serial-wire debug line engine
package swd_pkg;

  // command codes as they arrive on the input channel
  localparam logic [2:0] CMD_SHIFT_OUT = 3'd0;
  localparam logic [2:0] CMD_SHIFT_IN  = 3'd1;
  localparam logic [2:0] CMD_IDLE      = 3'd2;
  localparam logic [2:0] CMD_SET_DIR   = 3'd3;
  localparam logic [2:0] CMD_SET_RST   = 3'd4;

  typedef enum logic [2:0] {
    K_NONE,
    K_SHIFT_OUT,
    K_SHIFT_IN,
    K_IDLE,
    K_SET_DIR,
    K_SET_RST,
    K_BAD
  } swd_kind_t;

  typedef enum logic [1:0] {
    PH_READY,
    PH_LOW,
    PH_HIGH
  } swd_phase_t;

  typedef enum logic [1:0] {
    ACT_OUT,
    ACT_IN,
    ACT_IDLE
  } swd_act_t;

  typedef struct packed {
    logic        cmd_valid;
    logic [2:0]  command;
    logic [31:0] bits;
    logic [7:0]  count;
    logic        level;
    logic        line_in;
  } swd_in_t;

  typedef struct packed {
    logic        clock_out;
    logic        data_out;
    logic        data_drive;
    logic        reset_low;
    logic        busy_res;
    logic        done_res;
    logic        rejected;
    logic [31:0] read_word;
  } swd_out_t;

  // decoded beat handed from the front to the line engine
  typedef struct packed {
    swd_kind_t   kind;
    logic [7:0]  n;
    logic [31:0] bits;
    logic        level;
    logic        line_in;
  } swd_op_t;

endpackage

### rtl/swd_fifo.sv
// two-entry queue with registered status flags
module swd_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

### rtl/swd_front.sv
// input stage: takes a beat, classifies the command and saturates shift counts
module swd_front #(
  parameter int WORD_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  swd_pkg::swd_in_t in_data,
  output logic             full,
  output logic             op_valid,
  output swd_pkg::swd_op_t op,
  input  logic             op_full
);

  localparam logic [7:0] WordBitsN = 8'(WORD_BITS);

  logic             v_r, v_nxt;
  swd_pkg::swd_op_t op_r;
  swd_pkg::swd_op_t dec;
  logic             take, leave;
  logic [7:0]       n_sat;

  assign leave    = v_r && !op_full;
  assign full     = v_r && op_full;
  assign take     = push && !full;
  assign op_valid = v_r;
  assign op       = op_r;

  always_comb begin
    n_sat = (in_data.count > WordBitsN) ? WordBitsN : in_data.count;
    dec.bits    = in_data.bits;
    dec.level   = in_data.level;
    dec.line_in = in_data.line_in;
    dec.n       = n_sat;
    if (!in_data.cmd_valid) begin
      dec.kind = swd_pkg::K_NONE;
    end else begin
      unique case (in_data.command)
        swd_pkg::CMD_SHIFT_OUT: dec.kind = swd_pkg::K_SHIFT_OUT;
        swd_pkg::CMD_SHIFT_IN:  dec.kind = swd_pkg::K_SHIFT_IN;
        swd_pkg::CMD_IDLE: begin
          dec.kind = swd_pkg::K_IDLE;
          // idle clocks are not saturated
          dec.n    = in_data.count;
        end
        swd_pkg::CMD_SET_DIR:   dec.kind = swd_pkg::K_SET_DIR;
        swd_pkg::CMD_SET_RST:   dec.kind = swd_pkg::K_SET_RST;
        default:                dec.kind = swd_pkg::K_BAD;
      endcase
    end
  end

  always_comb begin
    v_nxt = take || (v_r && !leave);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op_r <= dec;
    end
  end

endmodule

### rtl/swd_back.sv
// line engine: phase sequencer, bit shifter and pin state, one beat per tick
module swd_back #(
  parameter int WORD_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data,
  input  logic              op_valid,
  input  swd_pkg::swd_op_t  op,
  output logic              op_pop,
  output logic              res_push,
  output swd_pkg::swd_out_t res,
  input  logic              res_full
);

  localparam int IdxW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

  logic [15:0]          half_period_r;
  swd_pkg::swd_phase_t  phase_r, phase_nxt;
  swd_pkg::swd_act_t    act_r, act_nxt;
  logic [15:0]          tick_r, tick_nxt;
  logic [7:0]           idx_r, idx_nxt;
  logic [7:0]           total_r, total_nxt;
  logic [WORD_BITS-1:0] shift_r, shift_nxt;
  logic                 clk_r, clk_nxt;
  logic                 data_r, data_nxt;
  logic                 drive_r, drive_nxt;
  logic                 rst_r, rst_nxt;
  logic                 fire;
  logic [WORD_BITS+31:0] bits_ext;
  logic [WORD_BITS+31:0] rd_ext;

  assign fire     = op_valid && !res_full;
  assign op_pop   = fire;
  assign res_push = fire;

  always_comb begin
    phase_nxt = phase_r;
    act_nxt   = act_r;
    tick_nxt  = tick_r;
    idx_nxt   = idx_r;
    total_nxt = total_r;
    shift_nxt = shift_r;
    clk_nxt   = clk_r;
    data_nxt  = data_r;
    drive_nxt = drive_r;
    rst_nxt   = rst_r;
    bits_ext  = {{WORD_BITS{1'b0}}, op.bits};
    rd_ext    = '0;
    res       = '0;

    if (op.kind != swd_pkg::K_NONE) begin
      if (phase_r != swd_pkg::PH_READY) begin
        res.rejected = 1'b1;
      end else begin
        unique case (op.kind)
          swd_pkg::K_NONE: begin
          end
          swd_pkg::K_SHIFT_OUT, swd_pkg::K_SHIFT_IN, swd_pkg::K_IDLE: begin
            if (op.kind == swd_pkg::K_IDLE) begin
              data_nxt = 1'b1;
            end
            if (op.n == 8'd0) begin
              res.done_res = 1'b1;
            end else begin
              if (op.kind == swd_pkg::K_SHIFT_OUT) begin
                shift_nxt = bits_ext[WORD_BITS-1:0];
                data_nxt  = op.bits[0];
                act_nxt   = swd_pkg::ACT_OUT;
              end else if (op.kind == swd_pkg::K_SHIFT_IN) begin
                shift_nxt = '0;
                act_nxt   = swd_pkg::ACT_IN;
              end else begin
                act_nxt   = swd_pkg::ACT_IDLE;
              end
              total_nxt = op.n;
              idx_nxt   = 8'd0;
              tick_nxt  = 16'd0;
              phase_nxt = swd_pkg::PH_LOW;
              clk_nxt   = 1'b0;
            end
          end
          swd_pkg::K_SET_DIR: begin
            drive_nxt    = op.level;
            res.done_res = 1'b1;
          end
          swd_pkg::K_SET_RST: begin
            rst_nxt      = op.level;
            res.done_res = 1'b1;
          end
          swd_pkg::K_BAD: begin
            res.rejected = 1'b1;
          end
          default: begin
            res.rejected = 1'b1;
          end
        endcase
      end
    end

    // pins as held during this tick
    res.clock_out  = clk_nxt;
    res.data_out   = data_nxt;
    res.data_drive = drive_nxt;
    res.reset_low  = rst_nxt;
    res.busy_res   = (phase_nxt != swd_pkg::PH_READY);

    if (phase_nxt != swd_pkg::PH_READY) begin
      if (tick_nxt < half_period_r) begin
        tick_nxt = tick_nxt + 16'd1;
      end else begin
        tick_nxt = 16'd0;
        if (phase_nxt == swd_pkg::PH_LOW) begin
          // sample at the end of the low phase
          if (act_nxt == swd_pkg::ACT_IN) begin
            shift_nxt[idx_nxt[IdxW-1:0]] = op.line_in;
          end
          clk_nxt   = 1'b1;
          phase_nxt = swd_pkg::PH_HIGH;
        end else begin
          idx_nxt = idx_nxt + 8'd1;
          if (act_nxt == swd_pkg::ACT_OUT) begin
            shift_nxt = shift_nxt >> 1;
          end
          if (idx_nxt >= total_nxt) begin
            phase_nxt    = swd_pkg::PH_READY;
            res.done_res = 1'b1;
            if (act_nxt == swd_pkg::ACT_IN) begin
              rd_ext        = {32'd0, shift_nxt};
              res.read_word = rd_ext[31:0];
            end
          end else begin
            clk_nxt = 1'b0;
            if (act_nxt == swd_pkg::ACT_OUT) begin
              data_nxt = shift_nxt[0];
            end
            phase_nxt = swd_pkg::PH_LOW;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= 16'd0;
    end else if (cfg_wr_en) begin
      half_period_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= swd_pkg::PH_READY;
      act_r   <= swd_pkg::ACT_OUT;
      tick_r  <= 16'd0;
      idx_r   <= 8'd0;
      total_r <= 8'd0;
      shift_r <= '0;
      clk_r   <= 1'b0;
      data_r  <= 1'b1;
      drive_r <= 1'b1;
      rst_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      act_r   <= act_nxt;
      tick_r  <= tick_nxt;
      idx_r   <= idx_nxt;
      total_r <= total_nxt;
      shift_r <= shift_nxt;
      clk_r   <= clk_nxt;
      data_r  <= data_nxt;
      drive_r <= drive_nxt;
      rst_r   <= rst_nxt;
    end
  end

endmodule

### rtl/swd_line_shift_engine_top.sv
// serial-wire debug line engine: front stage, command queue, line engine, result queue
//
// Each input beat is one tick of the debug line: the sampled SWDIO level plus
// an optional command (shift out, shift in, idle clocks, set direction, set reset).
// Every accepted beat yields exactly one result beat with the SWCLK, SWDIO,
// drive and reset pin levels for that tick, plus busy, done, rejected and the
// word collected by a shift-in.
// Input: a beat is taken when push is high and full is low.
// Output: the oldest result sits on out_data while empty is low and is taken
// when pop is high.
// cfg_wr_en/cfg_wr_data write half_period; write it only while the engine is idle.
// A beat passes the front register and the command queue; its result enters the result queue.
// Throughput: one beat per cycle; the engine takes one tick per cycle unless stalled.
// Reset puts the pins at clock low, data high, driving, target reset released,
// with half_period zero and both queues empty.
// When the receiver stalls, the result queue fills, the engine holds its state,
// and full rises once the command queue and front register are occupied.
module swd_line_shift_engine_top #(
  parameter int WORD_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  swd_pkg::swd_in_t  in_data,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output swd_pkg::swd_out_t out_data,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data
);

  localparam int OpW  = $bits(swd_pkg::swd_op_t);
  localparam int ResW = $bits(swd_pkg::swd_out_t);

  logic             fr_valid;
  swd_pkg::swd_op_t fr_op;
  logic             q_full, q_empty;
  logic [OpW-1:0]   q_dout;
  swd_pkg::swd_op_t q_op;
  logic             op_pop;
  logic             res_push, res_full;
  swd_pkg::swd_out_t res;
  logic [ResW-1:0]  res_dout;

  swd_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_data  (in_data),
    .full     (full),
    .op_valid (fr_valid),
    .op       (fr_op),
    .op_full  (q_full)
  );

  swd_fifo #(
    .WIDTH (OpW)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fr_valid),
    .din   (fr_op),
    .full  (q_full),
    .pop   (op_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign q_op = swd_pkg::swd_op_t'(q_dout);

  swd_back #(
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .op_valid    (!q_empty),
    .op          (q_op),
    .op_pop      (op_pop),
    .res_push    (res_push),
    .res         (res),
    .res_full    (res_full)
  );

  swd_fifo #(
    .WIDTH (ResW)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_dout),
    .empty (empty)
  );

  assign out_data = swd_pkg::swd_out_t'(res_dout);

endmodule
